// ----- hdl/tlsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tlsp_pkg: shared types and constants for the light sequencer
// Phase codes, run modes, register indexes, timing limits and lamp decode.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsp_pkg;

  localparam int unsigned DUR_W   = 14;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned LAMP_W  = 8;
  localparam int unsigned LED_W   = 2;
  localparam int unsigned PHASE_W = 3;

  localparam logic [DUR_W-1:0] TICK_MAX = 14'd9999;

  localparam logic [DUR_W-1:0] CLEAR_RST  = 14'd500;
  localparam logic [DUR_W-1:0] GREEN_RST  = 14'd6000;
  localparam logic [DUR_W-1:0] YELLOW_RST = 14'd2000;

  typedef enum logic [PHASE_W-1:0] {
    PH_RR      = 3'd0,
    PH_GR      = 3'd1,
    PH_GR_WALK = 3'd2,
    PH_YR      = 3'd3,
    PH_RR2     = 3'd4,
    PH_RG      = 3'd5,
    PH_RG_WALK = 3'd6,
    PH_RY      = 3'd7
  } phase_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALL_RED = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_SERVE   = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_NS_CLEAR  = 3'd0,
    REG_NS_GREEN  = 3'd1,
    REG_NS_YELLOW = 3'd2,
    REG_EW_CLEAR  = 3'd3,
    REG_EW_GREEN  = 3'd4,
    REG_EW_YELLOW = 3'd5,
    REG_RUN_MODE  = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  // Lamp bits
  localparam logic [LAMP_W-1:0] L_NS_G    = 8'b00000001;
  localparam logic [LAMP_W-1:0] L_NS_Y    = 8'b00000010;
  localparam logic [LAMP_W-1:0] L_NS_R    = 8'b00000100;
  localparam logic [LAMP_W-1:0] L_EW_G    = 8'b00001000;
  localparam logic [LAMP_W-1:0] L_EW_Y    = 8'b00010000;
  localparam logic [LAMP_W-1:0] L_EW_R    = 8'b00100000;
  localparam logic [LAMP_W-1:0] L_NS_WALK = 8'b01000000;
  localparam logic [LAMP_W-1:0] L_EW_WALK = 8'b10000000;

  typedef struct packed {
    logic [DUR_W-1:0] ns_clear;
    logic [DUR_W-1:0] ns_green;
    logic [DUR_W-1:0] ns_yellow;
    logic [DUR_W-1:0] ew_clear;
    logic [DUR_W-1:0] ew_green;
    logic [DUR_W-1:0] ew_yellow;
    mode_t            run_mode;
  } cfg_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic [LED_W-1:0]  request_leds;
    phase_t            phase;
  } res_t;

  function automatic logic [LAMP_W-1:0] lamp_decode(input phase_t p);
    logic [LAMP_W-1:0] l;
    case (p)
      PH_RR:      l = L_NS_R | L_EW_R;
      PH_GR:      l = L_NS_G | L_EW_R;
      PH_GR_WALK: l = L_NS_G | L_EW_R | L_NS_WALK;
      PH_YR:      l = L_NS_Y | L_EW_R;
      PH_RR2:     l = L_NS_R | L_EW_R;
      PH_RG:      l = L_NS_R | L_EW_G;
      PH_RG_WALK: l = L_NS_R | L_EW_G | L_EW_WALK;
      PH_RY:      l = L_NS_R | L_EW_Y;
      default:    l = L_NS_R | L_EW_R;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tlsp_cfg.sv -----
// ----------------------------------------------------------------------------
// tlsp_cfg: configuration register file
// Holds the six phase durations and the run mode, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsp_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [tlsp_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [tlsp_pkg::DUR_W-1:0]  wr_data,
  output tlsp_pkg::cfg_t                   cfg
);

  tlsp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ns_clear  <= tlsp_pkg::CLEAR_RST;
      cfg_r.ns_green  <= tlsp_pkg::GREEN_RST;
      cfg_r.ns_yellow <= tlsp_pkg::YELLOW_RST;
      cfg_r.ew_clear  <= tlsp_pkg::CLEAR_RST;
      cfg_r.ew_green  <= tlsp_pkg::GREEN_RST;
      cfg_r.ew_yellow <= tlsp_pkg::YELLOW_RST;
      cfg_r.run_mode  <= tlsp_pkg::MODE_ALL_RED;
    end else if (wr_en) begin
      case (tlsp_pkg::reg_idx_t'(wr_index))
        tlsp_pkg::REG_NS_CLEAR:  cfg_r.ns_clear  <= wr_data;
        tlsp_pkg::REG_NS_GREEN:  cfg_r.ns_green  <= wr_data;
        tlsp_pkg::REG_NS_YELLOW: cfg_r.ns_yellow <= wr_data;
        tlsp_pkg::REG_EW_CLEAR:  cfg_r.ew_clear  <= wr_data;
        tlsp_pkg::REG_EW_GREEN:  cfg_r.ew_green  <= wr_data;
        tlsp_pkg::REG_EW_YELLOW: cfg_r.ew_yellow <= wr_data;
        tlsp_pkg::REG_RUN_MODE:
          cfg_r.run_mode <= tlsp_pkg::mode_t'(wr_data[tlsp_pkg::MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hdl/tlsp_seq.sv -----
// ----------------------------------------------------------------------------
// tlsp_seq: phase sequencer
// Phase, tick counter and request latches; one update per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsp_seq (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic       tick,
  input  wire logic       ns_press,
  input  wire logic       ew_press,
  input  wire logic       hold_red,
  input  wire tlsp_pkg::cfg_t cfg,
  output tlsp_pkg::res_t  res_nxt
);

  tlsp_pkg::phase_t                phase_r, phase_nxt;
  logic [tlsp_pkg::DUR_W-1:0]      elapsed_r, elapsed_nxt;
  logic                            ns_req_r, ns_req_nxt;
  logic                            ew_req_r, ew_req_nxt;

  logic                            serving;
  logic                            running;
  logic [tlsp_pkg::DUR_W-1:0]      dur_raw;
  logic [tlsp_pkg::DUR_W-1:0]      dur;
  logic [tlsp_pkg::DUR_W-1:0]      elapsed_inc;
  logic                            all_red;

  assign serving = (cfg.run_mode == tlsp_pkg::MODE_SERVE);
  assign running = (cfg.run_mode == tlsp_pkg::MODE_PLAIN) || serving;

  always_comb begin
    case (phase_r)
      tlsp_pkg::PH_RR:      dur_raw = cfg.ns_clear;
      tlsp_pkg::PH_GR:      dur_raw = cfg.ns_green;
      tlsp_pkg::PH_GR_WALK: dur_raw = cfg.ns_green;
      tlsp_pkg::PH_YR:      dur_raw = cfg.ns_yellow;
      tlsp_pkg::PH_RR2:     dur_raw = cfg.ew_clear;
      tlsp_pkg::PH_RG:      dur_raw = cfg.ew_green;
      tlsp_pkg::PH_RG_WALK: dur_raw = cfg.ew_green;
      tlsp_pkg::PH_RY:      dur_raw = cfg.ew_yellow;
      default:              dur_raw = cfg.ew_yellow;
    endcase
  end

  assign dur         = (dur_raw > tlsp_pkg::TICK_MAX) ? tlsp_pkg::TICK_MAX : dur_raw;
  assign elapsed_inc = (elapsed_r >= tlsp_pkg::TICK_MAX) ? tlsp_pkg::TICK_MAX
                                                         : elapsed_r + tlsp_pkg::DUR_W'(1);
  assign all_red     = (phase_r == tlsp_pkg::PH_RR) || (phase_r == tlsp_pkg::PH_RR2);

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    ns_req_nxt  = ns_req_r;
    ew_req_nxt  = ew_req_r;
    if (!running) begin
      phase_nxt   = tlsp_pkg::PH_RR;
      elapsed_nxt = '0;
    end else begin
      if (serving) begin
        ns_req_nxt = ns_req_r | ns_press;
        ew_req_nxt = ew_req_r | ew_press;
      end
      if (tick) begin
        if (elapsed_inc < dur) begin
          elapsed_nxt = elapsed_inc;
        end else if (all_red && hold_red) begin
          // hold in all-red; the count keeps advancing and saturates at TICK_MAX
          elapsed_nxt = elapsed_inc;
        end else begin
          elapsed_nxt = '0;
          case (phase_r)
            tlsp_pkg::PH_RR: begin
              if (serving && ns_req_nxt) begin
                ns_req_nxt = 1'b0;
                phase_nxt  = tlsp_pkg::PH_GR_WALK;
              end else begin
                phase_nxt = tlsp_pkg::PH_GR;
              end
            end
            tlsp_pkg::PH_GR:      phase_nxt = tlsp_pkg::PH_YR;
            tlsp_pkg::PH_GR_WALK: phase_nxt = tlsp_pkg::PH_YR;
            tlsp_pkg::PH_YR:      phase_nxt = tlsp_pkg::PH_RR2;
            tlsp_pkg::PH_RR2: begin
              if (serving && ew_req_nxt) begin
                ew_req_nxt = 1'b0;
                phase_nxt  = tlsp_pkg::PH_RG_WALK;
              end else begin
                phase_nxt = tlsp_pkg::PH_RG;
              end
            end
            tlsp_pkg::PH_RG:      phase_nxt = tlsp_pkg::PH_RY;
            tlsp_pkg::PH_RG_WALK: phase_nxt = tlsp_pkg::PH_RY;
            tlsp_pkg::PH_RY:      phase_nxt = tlsp_pkg::PH_RR;
            default:              phase_nxt = tlsp_pkg::PH_RR;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= tlsp_pkg::PH_RR;
      elapsed_r <= '0;
      ns_req_r  <= 1'b0;
      ew_req_r  <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      ns_req_r  <= ns_req_nxt;
      ew_req_r  <= ew_req_nxt;
    end
  end

  always_comb begin
    res_nxt.lamps        = tlsp_pkg::lamp_decode(phase_nxt);
    res_nxt.request_leds = serving ? {ew_req_nxt, ns_req_nxt} : '0;
    res_nxt.phase        = phase_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/traffic_light_sequencer_pedestrian.sv -----
// ----------------------------------------------------------------------------
// traffic_light_sequencer_pedestrian: two-road light sequencer
// Eight-phase light cycle with pedestrian walk requests and all-red hold.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in_     | input     | in_valid / in_ready     | tick, ns_press, ew_press,
//           |           |                         | hold_red
//   out_    | output    | out_valid / out_ready   | lamps, request_leds, phase
//   cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One beat per cycle while in_ready is high: each accepted beat updates the
// sequencer state and loads one result into the output register on the same
// edge; the result appears in the cycle after acceptance. in_ready drops only
// while the output register is full and out_ready is low. Reset (rst_n low,
// sync) clears the phase to all-red, the count and request latches to zero, and
// loads the default durations with run mode all-red. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_sequencer_pedestrian (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_tick,
  input  wire logic                          in_ns_press,
  input  wire logic                          in_ew_press,
  input  wire logic                          in_hold_red,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [tlsp_pkg::LAMP_W-1:0]   out_lamps,
  output      logic [tlsp_pkg::LED_W-1:0]    out_request_leds,
  output      logic [tlsp_pkg::PHASE_W-1:0]  out_phase,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [tlsp_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [tlsp_pkg::DUR_W-1:0]    cfg_data
);

  tlsp_pkg::cfg_t cfg;
  tlsp_pkg::res_t res_nxt;
  tlsp_pkg::res_t res_r;
  logic           out_valid_r;
  logic           in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  tlsp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tlsp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (in_fire),
    .tick     (in_tick),
    .ns_press (in_ns_press),
    .ew_press (in_ew_press),
    .hold_red (in_hold_red),
    .cfg      (cfg),
    .res_nxt  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload: load on each accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lamps        = res_r.lamps;
  assign out_request_leds = res_r.request_leds;
  assign out_phase        = res_r.phase;

endmodule

`default_nettype wire
